/* src/dodpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dodpf_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_EMPTY = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Frame classes reported on latest_class.
    localparam logic [1:0] CLASS_NONE     = 2'd0;
    localparam logic [1:0] CLASS_REPEAT   = 2'd1;
    localparam logic [1:0] CLASS_NEW      = 2'd2;
    localparam logic [1:0] CLASS_TOO_LONG = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_POLL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* src/dedup_drop_oldest_payload_fifo_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame queue with consecutive duplicate suppression and drop-oldest overflow.
// Input channel (in_valid/in_ready) carries one request per item: a frame byte
// with its last mark, an empty-frame mark, a poll for one byte, or a clear.
// Output channel (out_valid/out_ready) returns exactly one result per request:
// the class of the last finished frame, the drop and queue counters, and for a
// poll the byte read from the head frame with its end mark and frame length.
// The block works on one request at a time. A byte, empty or clear request
// passes through the execute and done states; a poll that reads a byte also
// passes through the fetch and poll states in between, for the queue order read
// followed by the length and payload memory reads. The next request is accepted
// only once the result is loaded into the output register and the block is idle.
// A result sits in the output register while the next request is accepted and
// executed; if the receiver still stalls when the next result is ready, the
// sequencer holds in its final state until the output register frees up.
// Reset, and a clear request, empty the queue, free every buffer and zero the
// counters. The memories need no clearing: every read hits a written entry.
module dedup_drop_oldest_payload_fifo_unit #(
    parameter int RING_SLOTS  = 24,
    parameter int MAX_PAYLOAD = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       latest_class,
    output logic [31:0]      dropped_count,
    output logic [4:0]       queued_count,
    output logic             poll_valid,
    output logic [7:0]       poll_data,
    output logic             poll_end,
    output logic [12:0]      poll_length
);

    import dodpf_pkg::*;

    localparam int SLOTS  = RING_SLOTS + 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int Q_W    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int FILL_W = $clog2(RING_SLOTS + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int OFF_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 2);

    // Buffer payloads, the two banks of the last forwarded frame, buffer
    // lengths and the queue ring of buffer numbers.
    logic [7:0]        pay_mem [SLOTS * (2 ** OFF_W)];
    logic [7:0]        fwd_mem [2 * (2 ** OFF_W)];
    logic [LEN_W-1:0]  len_mem [SLOTS];
    logic [SLOT_W-1:0] ord_mem [RING_SLOTS];

    logic [7:0]        pay_rdata;
    logic [7:0]        fwd_rdata;
    logic [LEN_W-1:0]  len_rdata;
    logic [SLOT_W-1:0] ord_rdata;

    logic                    pay_we, fwd_we, len_we, ord_we;
    logic [SLOT_W+OFF_W-1:0] pay_waddr;
    logic [OFF_W:0]          fwd_waddr;
    logic [SLOT_W-1:0]       len_waddr;
    logic [Q_W-1:0]          ord_waddr;
    logic [LEN_W-1:0]        len_wdata;
    logic [SLOT_W-1:0]       ord_wdata;

    state_t state_reg, state_next;
    logic [1:0]        op_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [Q_W-1:0]    head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SLOT_W-1:0] stg_slot_reg, stg_slot_next;
    logic [LEN_W-1:0]  stg_len_reg, stg_len_next;
    logic              differs_reg, differs_next;
    logic [LEN_W-1:0]  fwd_len_reg, fwd_len_next;
    logic              bank_reg, bank_next;
    logic              have_fwd_reg, have_fwd_next;
    logic [SLOT_W-1:0] ro_slot_reg, ro_slot_next;
    logic [LEN_W-1:0]  ro_off_reg, ro_off_next;
    logic              ro_active_reg, ro_active_next;
    logic [1:0]        class_reg, class_next;
    logic [31:0]       drop_reg, drop_next;
    logic              res_pv_reg, res_pv_next;
    logic [7:0]        res_pd_reg, res_pd_next;
    logic              res_pe_reg, res_pe_next;
    logic [LEN_W-1:0]  res_pl_reg, res_pl_next;

    logic              out_valid_reg;
    logic [1:0]        out_class_reg;
    logic [31:0]       out_drop_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic              out_pv_reg;
    logic [7:0]        out_pd_reg;
    logic              out_pe_reg;
    logic [LEN_W-1:0]  out_pl_reg;

    logic              grab, rel_en, map_clear;
    logic [SLOT_W-1:0] rel_slot, grab_slot;

    logic              accept, load_out;
    logic [SLOT_W-1:0] stg_slot_now;
    logic              diff_now;
    logic [LEN_W-1:0]  len_new;
    logic [SUM_W-1:0]  tail_sum;
    logic [Q_W-1:0]    tail_idx, head_inc;
    logic [LEN_W-1:0]  off_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign stg_slot_now = (stg_len_reg == '0) ? grab_slot : stg_slot_reg;
    assign tail_sum     = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_idx     = (tail_sum >= SUM_W'(RING_SLOTS)) ?
                          Q_W'(tail_sum - SUM_W'(RING_SLOTS)) : Q_W'(tail_sum);
    assign head_inc     = (head_reg == Q_W'(RING_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign off_inc      = ro_off_reg + 1'b1;

    dodpf_free_map #(
        .SLOTS (SLOTS)
    ) u_free_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (map_clear),
        .grab      (grab),
        .rel_en    (rel_en),
        .rel_slot  (rel_slot),
        .grab_slot (grab_slot)
    );

    // Memories: one write port, one registered read port each. Read addresses
    // come straight from the state registers, so the data lines up with the
    // cycle after those registers settle.
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= byte_reg;
        end
        pay_rdata <= pay_mem[{ro_slot_reg, ro_off_reg[OFF_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= byte_reg;
        end
        fwd_rdata <= fwd_mem[{bank_reg, stg_len_reg[OFF_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[ro_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata <= ord_mem[head_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        stg_slot_next  = stg_slot_reg;
        stg_len_next   = stg_len_reg;
        differs_next   = differs_reg;
        fwd_len_next   = fwd_len_reg;
        bank_next      = bank_reg;
        have_fwd_next  = have_fwd_reg;
        ro_slot_next   = ro_slot_reg;
        ro_off_next    = ro_off_reg;
        ro_active_next = ro_active_reg;
        class_next     = class_reg;
        drop_next      = drop_reg;
        res_pv_next    = res_pv_reg;
        res_pd_next    = res_pd_reg;
        res_pe_next    = res_pe_reg;
        res_pl_next    = res_pl_reg;
        pay_we         = 1'b0;
        fwd_we         = 1'b0;
        len_we         = 1'b0;
        ord_we         = 1'b0;
        pay_waddr      = {stg_slot_now, stg_len_reg[OFF_W-1:0]};
        fwd_waddr      = {~bank_reg, stg_len_reg[OFF_W-1:0]};
        len_waddr      = stg_slot_now;
        len_wdata      = '0;
        ord_waddr      = tail_idx;
        ord_wdata      = stg_slot_now;
        grab           = 1'b0;
        rel_en         = 1'b0;
        rel_slot       = stg_slot_now;
        map_clear      = 1'b0;
        diff_now       = 1'b0;
        len_new        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_pv_next = 1'b0;
                res_pd_next = '0;
                res_pe_next = 1'b0;
                res_pl_next = '0;
                state_next  = ST_DONE;
                unique case (op_reg)
                    OP_BYTE:
                    begin
                        grab          = (stg_len_reg == '0);
                        stg_slot_next = stg_slot_now;
                        diff_now      = (stg_len_reg == '0) ? 1'b0 : differs_reg;
                        if (stg_len_reg < LEN_W'(MAX_PAYLOAD))
                        begin
                            pay_we = 1'b1;
                            fwd_we = 1'b1;
                            if (!have_fwd_reg || stg_len_reg >= fwd_len_reg ||
                                fwd_rdata != byte_reg)
                            begin
                                diff_now = 1'b1;
                            end
                            len_new = stg_len_reg + 1'b1;
                        end
                        else
                        begin
                            len_new = LEN_W'(MAX_PAYLOAD + 1);
                        end
                        stg_len_next = len_new;
                        differs_next = diff_now;
                        if (last_reg)
                        begin
                            stg_len_next = '0;
                            differs_next = 1'b0;
                            if (len_new > LEN_W'(MAX_PAYLOAD))
                            begin
                                class_next = CLASS_TOO_LONG;
                                rel_en     = 1'b1;
                            end
                            else if (have_fwd_reg && !diff_now && len_new == fwd_len_reg)
                            begin
                                class_next = CLASS_REPEAT;
                                rel_en     = 1'b1;
                            end
                            else
                            begin
                                bank_next     = ~bank_reg;
                                fwd_len_next  = len_new;
                                have_fwd_next = 1'b1;
                                len_we        = 1'b1;
                                len_wdata     = len_new;
                                ord_we        = 1'b1;
                                class_next    = CLASS_NEW;
                                if (fill_reg == FILL_W'(RING_SLOTS))
                                begin
                                    // Queue full: the oldest frame gives way.
                                    rel_en    = 1'b1;
                                    rel_slot  = ord_rdata;
                                    head_next = head_inc;
                                    if (drop_reg != '1)
                                    begin
                                        drop_next = drop_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                    end
                    OP_EMPTY:
                    begin
                        rel_en       = (stg_len_reg != '0);
                        rel_slot     = stg_slot_reg;
                        stg_len_next = '0;
                        differs_next = 1'b0;
                        class_next   = CLASS_NONE;
                    end
                    OP_POLL:
                    begin
                        if (!ro_active_reg && fill_reg != '0)
                        begin
                            ro_slot_next   = ord_rdata;
                            head_next      = head_inc;
                            fill_next      = fill_reg - 1'b1;
                            ro_off_next    = '0;
                            ro_active_next = 1'b1;
                            state_next     = ST_FETCH;
                        end
                        else if (ro_active_reg)
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    OP_CLEAR:
                    begin
                        map_clear      = 1'b1;
                        head_next      = '0;
                        fill_next      = '0;
                        stg_slot_next  = '0;
                        stg_len_next   = '0;
                        differs_next   = 1'b0;
                        fwd_len_next   = '0;
                        bank_next      = 1'b0;
                        have_fwd_next  = 1'b0;
                        ro_slot_next   = '0;
                        ro_off_next    = '0;
                        ro_active_next = 1'b0;
                        class_next     = CLASS_NONE;
                        drop_next      = '0;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FETCH:
            begin
                state_next = ST_POLL;
            end
            ST_POLL:
            begin
                res_pv_next = 1'b1;
                res_pd_next = pay_rdata;
                res_pl_next = len_rdata;
                res_pe_next = 1'b0;
                ro_off_next = off_inc;
                if (off_inc >= len_rdata)
                begin
                    res_pe_next    = 1'b1;
                    ro_active_next = 1'b0;
                    rel_en         = 1'b1;
                    rel_slot       = ro_slot_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            stg_slot_reg  <= '0;
            stg_len_reg   <= '0;
            differs_reg   <= 1'b0;
            fwd_len_reg   <= '0;
            bank_reg      <= 1'b0;
            have_fwd_reg  <= 1'b0;
            ro_slot_reg   <= '0;
            ro_off_reg    <= '0;
            ro_active_reg <= 1'b0;
            class_reg     <= CLASS_NONE;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            stg_slot_reg  <= stg_slot_next;
            stg_len_reg   <= stg_len_next;
            differs_reg   <= differs_next;
            fwd_len_reg   <= fwd_len_next;
            bank_reg      <= bank_next;
            have_fwd_reg  <= have_fwd_next;
            ro_slot_reg   <= ro_slot_next;
            ro_off_reg    <= ro_off_next;
            ro_active_reg <= ro_active_next;
            class_reg     <= class_next;
            drop_reg      <= drop_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        res_pv_reg <= res_pv_next;
        res_pd_reg <= res_pd_next;
        res_pe_reg <= res_pe_next;
        res_pl_reg <= res_pl_next;
        if (load_out)
        begin
            out_class_reg <= class_reg;
            out_drop_reg  <= drop_reg;
            out_fill_reg  <= fill_reg;
            out_pv_reg    <= res_pv_reg;
            out_pd_reg    <= res_pd_reg;
            out_pe_reg    <= res_pe_reg;
            out_pl_reg    <= res_pl_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign latest_class  = out_class_reg;
    assign dropped_count = out_drop_reg;
    assign queued_count  = 5'(out_fill_reg);
    assign poll_valid    = out_pv_reg;
    assign poll_data     = out_pd_reg;
    assign poll_end      = out_pe_reg;
    assign poll_length   = 13'(out_pl_reg);

    // One request at a time: acceptance is always followed by a busy cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while the previous one was executing");

    // The queue never holds more frames than the ring has places.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_SLOTS))
        else $error("queue fill exceeds ring size");

    // A result without a polled byte carries zero poll fields.
    a_poll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !poll_valid) |-> (poll_data == '0 && !poll_end && poll_length == '0))
        else $error("poll fields set without a polled byte");

endmodule

`default_nettype wire

/* src/dodpf_free_map.sv */
`timescale 1ns / 1ps
`default_nettype none

// Free buffer map: one bit per buffer, lowest free buffer offered for grabbing.
module dodpf_free_map #(
    parameter int SLOTS = 26,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              grab,
    input  wire logic              rel_en,
    input  wire logic [SLOT_W-1:0] rel_slot,
    output logic      [SLOT_W-1:0] grab_slot
);

    logic [SLOTS-1:0] free_reg;
    logic [SLOTS-1:0] free_next;

    always_comb
    begin
        grab_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                grab_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        free_next = free_reg;
        if (grab)
        begin
            free_next[grab_slot] = 1'b0;
        end
        if (rel_en)
        begin
            free_next[rel_slot] = 1'b1;
        end
        if (clear)
        begin
            free_next = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

endmodule

`default_nettype wire
